FILE: design/lsf_pkg.sv
// ----------------------------------------------------------------------------
// lsf_pkg
// Types, codes and helpers for the logic, shift and flag unit.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [3:0] {
    OP_AND   = 4'd0,
    OP_OR    = 4'd1,
    OP_XOR   = 4'd2,
    OP_TEST  = 4'd3,
    OP_NOT   = 4'd4,
    OP_ROL   = 4'd5,
    OP_SAR   = 4'd6,
    OP_SHL   = 4'd7,
    OP_SHR   = 4'd8,
    OP_SETCC = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    SIZE_BYTE  = 2'd0,
    SIZE_WORD  = 2'd1,
    SIZE_DWORD = 2'd2
  } size_e;

  // condition pairs, selected by cond_code[3:1]
  typedef enum logic [2:0] {
    CC_O  = 3'd0,
    CC_B  = 3'd1,
    CC_E  = 3'd2,
    CC_BE = 3'd3,
    CC_S  = 3'd4,
    CC_P  = 3'd5,
    CC_L  = 3'd6,
    CC_LE = 3'd7
  } cond_e;

  typedef struct packed {
    logic [3:0]        op;
    logic [1:0]        size_code;
    logic [DATA_W-1:0] dest_value;
    logic [DATA_W-1:0] src_value;
    logic [3:0]        cond_code;
  } lsf_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] result_value;
    logic              write_back;
    logic              carry_flag;
    logic              overflow_flag;
    logic              zero_flag;
    logic              sign_flag;
    logic              bad_condition;
  } lsf_out_t;

  typedef struct packed {
    logic sf;
    logic zf;
    logic of;
    logic cf;
  } flags_t;

endpackage

FILE: design/lsf_alu.sv
// ----------------------------------------------------------------------------
// lsf_alu
// Single-pass execute logic: result, write enable and next flag set.
// ----------------------------------------------------------------------------
module lsf_alu
  import lsf_pkg::*;
(
  input  lsf_in_t  item_i,
  input  flags_t   flags_i,
  output lsf_out_t res_o,
  output flags_t   flags_o
);

  function automatic logic msb_of(logic [DATA_W-1:0] v, logic [1:0] sz);
    logic m;
    case (sz)
      SIZE_BYTE: m = v[7];
      SIZE_WORD: m = v[15];
      default:   m = v[DATA_W-1];
    endcase
    return m;
  endfunction

  logic [DATA_W-1:0]   mask;
  logic [DATA_W-1:0]   a;
  logic [DATA_W-1:0]   b;
  logic [COUNT_W-1:0]  cnt;
  logic [15:0]         rot8;
  logic [31:0]         rot16;
  logic [63:0]         rot32;
  logic [DATA_W-1:0]   rol_r;
  logic [DATA_W-1:0]   sext;
  logic [DATA_W-1:0]   sar_r;
  logic [DATA_W-1:0]   r;
  logic                wb;
  logic                bad;
  logic                base;
  logic                upd_zs;
  flags_t              fl;

  always_comb begin
    case (item_i.size_code)
      SIZE_BYTE: mask = 32'h0000_00ff;
      SIZE_WORD: mask = 32'h0000_ffff;
      default:   mask = 32'hffff_ffff;
    endcase
    a   = item_i.dest_value & mask;
    b   = item_i.src_value & mask;
    cnt = item_i.src_value[COUNT_W-1:0];

    rot8  = {a[7:0], a[7:0]} << cnt[2:0];
    rot16 = {a[15:0], a[15:0]} << cnt[3:0];
    rot32 = {a, a} << cnt;
    case (item_i.size_code)
      SIZE_BYTE: rol_r = {24'h0, rot8[15:8]};
      SIZE_WORD: rol_r = {16'h0, rot16[31:16]};
      default:   rol_r = rot32[63:32];
    endcase

    case (item_i.size_code)
      SIZE_BYTE: sext = {{24{a[7]}}, a[7:0]};
      SIZE_WORD: sext = {{16{a[15]}}, a[15:0]};
      default:   sext = a;
    endcase
    sar_r = DATA_W'($signed(sext) >>> cnt) & mask;

    r      = '0;
    wb     = 1'b0;
    bad    = 1'b0;
    base   = 1'b0;
    upd_zs = 1'b0;
    fl     = flags_i;

    case (item_i.op)
      OP_AND, OP_TEST: begin
        r      = a & b;
        wb     = (item_i.op != OP_TEST);
        fl.cf  = 1'b0;
        fl.of  = 1'b0;
        upd_zs = 1'b1;
      end
      OP_OR: begin
        r      = a | b;
        wb     = 1'b1;
        fl.cf  = 1'b0;
        fl.of  = 1'b0;
        upd_zs = 1'b1;
      end
      OP_XOR: begin
        r      = a ^ b;
        wb     = 1'b1;
        fl.cf  = 1'b0;
        fl.of  = 1'b0;
        upd_zs = 1'b1;
      end
      OP_NOT: begin
        r  = ~a & mask;
        wb = 1'b1;
      end
      OP_ROL: begin
        if (cnt == '0) begin
          r = a;
        end else begin
          r     = rol_r;
          wb    = 1'b1;
          fl.cf = rol_r[0];
          if (cnt == COUNT_W'(1)) begin
            fl.of = msb_of(rol_r, item_i.size_code) ^ rol_r[0];
          end
        end
      end
      OP_SAR: begin
        r      = sar_r;
        wb     = 1'b1;
        upd_zs = 1'b1;
      end
      OP_SHL: begin
        r      = (a << cnt) & mask;
        wb     = 1'b1;
        upd_zs = 1'b1;
      end
      OP_SHR: begin
        r      = a >> cnt;
        wb     = 1'b1;
        upd_zs = 1'b1;
      end
      OP_SETCC: begin
        case (item_i.cond_code[3:1])
          CC_O:    base = flags_i.of;
          CC_B:    base = flags_i.cf;
          CC_E:    base = flags_i.zf;
          CC_BE:   base = flags_i.cf | flags_i.zf;
          CC_S:    base = flags_i.sf;
          CC_P:    bad  = 1'b1;
          CC_L:    base = flags_i.sf ^ flags_i.of;
          default: base = flags_i.zf | (flags_i.sf ^ flags_i.of);
        endcase
        if (!bad) begin
          r  = {{(DATA_W-1){1'b0}}, base ^ item_i.cond_code[0]};
          wb = 1'b1;
        end
      end
      default: ;
    endcase

    if (upd_zs) begin
      fl.zf = (r == '0);
      fl.sf = msb_of(r, item_i.size_code);
    end
  end

  assign flags_o = fl;

  always_comb begin
    res_o.result_value  = r;
    res_o.write_back    = wb;
    res_o.carry_flag    = fl.cf;
    res_o.overflow_flag = fl.of;
    res_o.zero_flag     = fl.zf;
    res_o.sign_flag     = fl.sf;
    res_o.bad_condition = bad;
  end

endmodule

FILE: design/x86_logic_shift_flag_unit.sv
// ----------------------------------------------------------------------------
// x86_logic_shift_flag_unit
// i386 logic, rotate, shift and setcc group with a kept CF/OF/ZF/SF set.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | lsf_in_t  in_data_i
//   out     | output    | out_valid_o/out_stall_i | lsf_out_t out_data_o
//
// The result is registered behind the input register; one item per cycle is
// sustained while the result side does not stall.
// Input register, then execute logic, then result register; the flag register
// updates as an item moves into the result register.
// Reset clears valids and flags. A stalled result holds and backs up the input
// register; the input side stalls only when both registers are full.
// ----------------------------------------------------------------------------
module x86_logic_shift_flag_unit
  import lsf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  lsf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output lsf_out_t out_data_o
);

  logic     s1_valid_q, s1_valid_d;
  lsf_in_t  s1_q;
  logic     out_valid_q, out_valid_d;
  lsf_out_t out_q;
  flags_t   flags_q;
  flags_t   flags_d;
  lsf_out_t res;
  logic     advance;
  logic     in_take;

  lsf_alu u_alu (
    .item_i  (s1_q),
    .flags_i (flags_q),
    .res_o   (res),
    .flags_o (flags_d)
  );

  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && out_valid_q && out_stall_i;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d  = in_take || (s1_valid_q && !advance);
    out_valid_d = advance || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      flags_q     <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        flags_q <= flags_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q <= in_data_i;
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // the held result is always the latest item to pass the flag register
  a_flags_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.carry_flag == flags_q.cf) &&
                    (out_data_o.overflow_flag == flags_q.of) &&
                    (out_data_o.zero_flag == flags_q.zf) &&
                    (out_data_o.sign_flag == flags_q.sf))
    else $error("result flags differ from kept flags");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("input stalled with a free register");

  a_bad_cond: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_condition |->
      !out_data_o.write_back && (out_data_o.result_value == '0))
    else $error("parity condition produced a write");

  a_flags_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(flags_q))
    else $error("flags changed without a transfer");

endmodule

FILE: sim/x86_logic_shift_flag_unit_tb.sv
// ----------------------------------------------------------------------------
// x86_logic_shift_flag_unit_tb
// Self-checking bench for the i386 logic, shift and setcc unit. A short
// directed list hits operand extremes, odd rotate and shift counts, parity
// conditions, the spare size code and unused opcodes. A long random stream
// follows, with random gaps on the input and random stalls on the result side.
// A scoreboard keeps its own copy of the CF/OF/ZF/SF set, predicts each result
// as an input transfer is accepted, and compares every result field by field.
// ----------------------------------------------------------------------------
module x86_logic_shift_flag_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lsf_pkg::*;

  localparam logic [3:0]  OP_UNUSED_LO   = 4'd10;
  localparam logic [3:0]  OP_UNUSED_HI   = 4'd15;
  localparam logic [1:0]  SIZE_SPARE     = 2'd3;
  localparam int unsigned RANDOM_ITEMS   = 1680;
  localparam int unsigned CALM_ITEMS     = 200;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  class flag_scoreboard;
    flags_t      kept = '0;
    lsf_out_t    expected_q[$];
    int unsigned noted;
    int unsigned checked;
    int unsigned mismatches;
    int unsigned parity_hits;

    function void set_zf_sf(logic [31:0] r, int unsigned bits);
      kept.zf = (r == '0);
      kept.sf = r[bits-1];
    endfunction

    function lsf_out_t execute(lsf_in_t it);
      int unsigned bits;
      int unsigned rot;
      int unsigned sh;
      logic [31:0] mask;
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] r;
      logic [COUNT_W-1:0] cnt;
      logic        cond;
      lsf_out_t    res;
      bits = (it.size_code == SIZE_BYTE) ? 8 : (it.size_code == SIZE_WORD) ? 16 : 32;
      mask = (bits == 32) ? '1 : ((32'd1 << bits) - 32'd1);
      a    = it.dest_value & mask;
      b    = it.src_value & mask;
      cnt  = it.src_value[COUNT_W-1:0];
      r    = '0;
      cond = 1'b0;
      res  = '0;
      case (it.op)
        OP_AND, OP_OR, OP_XOR, OP_TEST: begin
          r = (it.op == OP_OR) ? (a | b) : (it.op == OP_XOR) ? (a ^ b) : (a & b);
          res.write_back = (it.op != OP_TEST);
          kept.cf = 1'b0;
          kept.of = 1'b0;
          set_zf_sf(r, bits);
        end
        OP_NOT: begin
          r = ~a & mask;
          res.write_back = 1'b1;
        end
        OP_ROL: begin
          if (cnt == '0) begin
            r = a;
          end else begin
            rot = cnt % bits;
            r = (rot == 0) ? a : (((a << rot) | (a >> (bits - rot))) & mask);
            res.write_back = 1'b1;
            kept.cf = r[0];
            if (cnt == 1) kept.of = r[bits-1] ^ r[0];
          end
        end
        OP_SAR: begin
          sh = (cnt >= bits) ? bits - 1 : cnt;
          r  = a >> sh;
          if (a[bits-1]) r = r | ~(mask >> sh);
          r = r & mask;
          res.write_back = 1'b1;
          set_zf_sf(r, bits);
        end
        OP_SHL: begin
          r = (a << cnt) & mask;
          res.write_back = 1'b1;
          set_zf_sf(r, bits);
        end
        OP_SHR: begin
          r = a >> cnt;
          res.write_back = 1'b1;
          set_zf_sf(r, bits);
        end
        OP_SETCC: begin
          case (it.cond_code[3:1])
            CC_O:    cond = kept.of;
            CC_B:    cond = kept.cf;
            CC_E:    cond = kept.zf;
            CC_BE:   cond = kept.cf | kept.zf;
            CC_S:    cond = kept.sf;
            CC_P:    res.bad_condition = 1'b1;
            CC_L:    cond = kept.sf ^ kept.of;
            default: cond = kept.zf | (kept.sf ^ kept.of);
          endcase
          if (!res.bad_condition) begin
            r = {31'b0, cond ^ it.cond_code[0]};
            res.write_back = 1'b1;
          end
        end
        default: ;
      endcase
      res.result_value  = r;
      res.carry_flag    = kept.cf;
      res.overflow_flag = kept.of;
      res.zero_flag     = kept.zf;
      res.sign_flag     = kept.sf;
      return res;
    endfunction

    function void note_input(lsf_in_t it);
      lsf_out_t want;
      want = execute(it);
      if (want.bad_condition) parity_hits++;
      expected_q.push_back(want);
      noted++;
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("[%0t] mismatch on %s at result %0d: got 0x%0h, expected 0x%0h",
               $time, field, checked, got, want);
      mismatches++;
    endtask

    task check_result(lsf_out_t got);
      lsf_out_t want;
      if (expected_q.size() == 0) begin
        report_mismatch("result with no transfer pending", got.result_value, '0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.result_value !== want.result_value)
        report_mismatch("result_value", got.result_value, want.result_value);
      if (got.write_back !== want.write_back)
        report_mismatch("write_back", 32'(got.write_back), 32'(want.write_back));
      if (got.carry_flag !== want.carry_flag)
        report_mismatch("carry_flag", 32'(got.carry_flag), 32'(want.carry_flag));
      if (got.overflow_flag !== want.overflow_flag)
        report_mismatch("overflow_flag", 32'(got.overflow_flag),
                        32'(want.overflow_flag));
      if (got.zero_flag !== want.zero_flag)
        report_mismatch("zero_flag", 32'(got.zero_flag), 32'(want.zero_flag));
      if (got.sign_flag !== want.sign_flag)
        report_mismatch("sign_flag", 32'(got.sign_flag), 32'(want.sign_flag));
      if (got.bad_condition !== want.bad_condition)
        report_mismatch("bad_condition", 32'(got.bad_condition),
                        32'(want.bad_condition));
    endtask
  endclass

  logic     clk = 1'b0;
  logic     rst_ni;
  logic     in_valid;
  logic     in_stall_o;
  lsf_in_t  in_data;
  logic     out_valid_o;
  logic     out_stall;
  lsf_out_t out_data_o;

  bit             calm = 1'b0;
  int unsigned    stuck_cycles = 0;
  flag_scoreboard sb = new;

  x86_logic_shift_flag_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic lsf_in_t instr(logic [3:0] op, logic [1:0] size, logic [31:0] d,
                                    logic [31:0] s, logic [3:0] cc);
    lsf_in_t it;
    it.op         = op;
    it.size_code  = size;
    it.dest_value = d;
    it.src_value  = s;
    it.cond_code  = cc;
    return it;
  endfunction

  // biased toward values that make ZF, SF and sign fill show up
  function automatic logic [31:0] rand_operand();
    logic [31:0] bit_k;
    bit_k = 32'd1 << $urandom_range(0, 31);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return bit_k;
      3:       return ~bit_k;
      4:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(lsf_in_t it);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall_o);
    sb.note_input(it);
  endtask

  // result side: stall bursts, none in the calm tail
  initial begin
    out_stall = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  // result checks and watchdog
  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall) sb.check_result(out_data_o);
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    lsf_in_t it;
    rst_ni   = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (12) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    send_item(instr(OP_AND,   SIZE_DWORD, '1,           '1,           '0));
    send_item(instr(OP_SETCC, SIZE_BYTE,  '0,           '0,           {CC_S, 1'b0}));
    send_item(instr(OP_AND,   SIZE_BYTE,  32'hffff_ffaa, 32'h0000_0055, '0));
    send_item(instr(OP_OR,    SIZE_WORD,  32'hffff_0000, 32'h0001_0000, '0));
    send_item(instr(OP_XOR,   SIZE_SPARE, 32'h8000_0000, '0,           '0));
    send_item(instr(OP_TEST,  SIZE_BYTE,  32'h0000_00ff, 32'h0000_0080, '0));
    send_item(instr(OP_NOT,   SIZE_WORD,  32'hdead_1234, '0,           '0));
    send_item(instr(OP_ROL,   SIZE_BYTE,  32'h0000_0081, 32'd1,        '0));
    send_item(instr(OP_SETCC, SIZE_BYTE,  '0,           '0,           {CC_O, 1'b0}));
    send_item(instr(OP_ROL,   SIZE_BYTE,  32'h0000_00c3, 32'hffff_ffe0, '0));
    send_item(instr(OP_ROL,   SIZE_BYTE,  32'h0000_0081, 32'd8,        '0));
    send_item(instr(OP_ROL,   SIZE_WORD,  32'h0000_8001, 32'd16,       '0));
    send_item(instr(OP_ROL,   SIZE_DWORD, 32'h8000_0001, 32'd31,       '0));
    send_item(instr(OP_SETCC, SIZE_BYTE,  '0,           '0,           {CC_B, 1'b1}));
    send_item(instr(OP_SAR,   SIZE_BYTE,  32'h0000_0080, 32'd31,       '0));
    send_item(instr(OP_SAR,   SIZE_DWORD, 32'h8000_0000, 32'd4,        '0));
    send_item(instr(OP_SAR,   SIZE_WORD,  32'h0000_7fff, 32'd20,       '0));
    send_item(instr(OP_SHL,   SIZE_BYTE,  32'h0000_0001, 32'd8,        '0));
    send_item(instr(OP_SHL,   SIZE_DWORD, '1,           '0,           '0));
    send_item(instr(OP_SHR,   SIZE_WORD,  32'h0000_8000, 32'd15,       '0));
    send_item(instr(OP_SHR,   SIZE_DWORD, '1,           '1,           '0));
    send_item(instr(OP_SETCC, SIZE_BYTE,  '0,           '0,           {CC_P, 1'b0}));
    send_item(instr(OP_SETCC, SIZE_BYTE,  '0,           '0,           {CC_P, 1'b1}));
    send_item(instr(OP_SETCC, SIZE_BYTE,  '0,           '0,           {CC_LE, 1'b1}));
    send_item(instr(OP_UNUSED_LO, SIZE_DWORD, '1,       '1,           '1));
    send_item(instr(OP_UNUSED_HI, SIZE_BYTE,  '1,       '1,           '1));

    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      it.op = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI))
                                          : 4'($urandom_range(OP_AND, OP_SETCC));
      it.size_code  = 2'($urandom_range(0, 3));
      it.dest_value = rand_operand();
      it.src_value  = rand_operand();
      it.cond_code  = 4'($urandom_range(0, 15));
      send_item(it);
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d instructions (all ops, sizes, unused opcodes), %0d results compared",
             sb.noted, sb.checked);
    $display("parity setcc requests: %0d, mismatches: %0d", sb.parity_hits, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
